### rtl/rmt_pkg.sv
// Package for the range minimum tree: sizes, kind codes, sequencer states
// and the shared min helper. No dependencies.
package rmt_pkg;

    localparam int SIZE       = 1024;              // slots (power of two)
    localparam int IDX_W      = 10;                // slot index field width
    localparam int NODE_W     = IDX_W + 1;         // tree node address width
    localparam int NODE_COUNT = 2 * SIZE;
    localparam int Q_W        = NODE_W + 1;        // query bounds reach NODE_COUNT
    localparam int VALUE_BITS = 48;
    localparam int S_TDATA_W  = 72;                // index_low, index_high, value
    localparam int M_TDATA_W  = 48;                // min_value

    localparam logic [VALUE_BITS-1:0] EMPTY_VAL = '1;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOWER = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_L_CMP,
        ST_U_WR,
        ST_Q_A,
        ST_Q_B,
        ST_RESP
    } state_t;

    function automatic logic [VALUE_BITS-1:0] val_min(
        input logic [VALUE_BITS-1:0] a,
        input logic [VALUE_BITS-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

### rtl/range_min_tree.sv
// Range minimum tree: top level with the node memory and its sequencer.
// Depends on rmt_pkg.
//
// range_min_tree keeps SIZE slots of unsigned 48-bit values as a binary min
// tree in one synchronous node memory (2*SIZE entries, one write and one
// read port, read data registered). Slot i is leaf SIZE+i; node k holds the
// min of nodes 2k and 2k+1; an empty slot is stored as all ones. Each input
// transaction (kind in s_tuser) gives exactly one result transaction.
// Clear rewrites every node, one per cycle, then shows its result and returns
// to idle. The same pass runs after reset, with s_tready low, and gives no
// result. A lower request reads the leaf, and when the new value is smaller
// writes it and walks up one ancestor per cycle, reading the sibling while
// writing the parent; when the slot already holds a value that is not larger
// it writes nothing and goes straight to the result. A range query visits at
// most two nodes per level, and a reversed range goes straight to the result.
// The single read port of the node memory paces these walks. One item is in
// work at a time; the output register lets the next item enter while a result
// waits on m_tready.
// Non-query results carry min_value 0 and empty_res 0; an empty or reversed
// query gives empty_res 1 with min_value 0.
module range_min_tree
    import rmt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // index_low[9:0], index_high[19:10],
                                             // value[67:20], zero pad[71:68]
    input  logic [1:0]            s_tuser,   // kind[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // min_value[47:0]
    output logic                  m_tuser    // empty_res
);

    // Node memory
    logic [VALUE_BITS-1:0] tree_mem [NODE_COUNT];
    logic [VALUE_BITS-1:0] mem_rdata_reg;
    logic                  mem_we;
    logic [NODE_W-1:0]     mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [NODE_W-1:0]     mem_raddr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tree_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= tree_mem[mem_raddr];
        end
    end

    // Sequencer state
    state_t                state_reg,      state_next;
    logic [NODE_W-1:0]     sweep_reg,      sweep_next;
    logic                  clear_pend_reg, clear_pend_next;
    logic                  op_query_reg,   op_query_next;
    logic [VALUE_BITS-1:0] val_reg,        val_next;
    logic [NODE_W-1:0]     node_reg,       node_next;
    logic [VALUE_BITS-1:0] best_reg,       best_next;   // running min / carried min
    logic [Q_W-1:0]        l_reg,          l_next;
    logic [Q_W-1:0]        r_reg,          r_next;
    logic                  pend_l_reg,     pend_l_next; // read of left node in flight
    logic                  pend_r_reg,     pend_r_next; // read of right node in flight
    logic                  m_tvalid_reg,   m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg,    m_tdata_next;
    logic                  m_tuser_reg,    m_tuser_next;

    // Input fields
    logic [IDX_W-1:0]      in_lo;
    logic [IDX_W-1:0]      in_hi;
    logic [VALUE_BITS-1:0] in_val;
    logic [NODE_W-1:0]     hi_eff;
    logic                  in_accept;

    assign in_lo     = s_tdata[IDX_W-1:0];
    assign in_hi     = s_tdata[2*IDX_W-1:IDX_W];
    assign in_val    = s_tdata[2*IDX_W+VALUE_BITS-1:2*IDX_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Query end clipped to the last slot
    assign hi_eff = (NODE_W'(in_hi) >= NODE_W'(SIZE)) ? NODE_W'(SIZE - 1) : NODE_W'(in_hi);

    // Scratch values for the walk
    logic [VALUE_BITS-1:0] absorb;
    logic [NODE_W-1:0]     parent;
    logic [Q_W-1:0]        r_dec;

    always_comb begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        clear_pend_next = clear_pend_reg;
        op_query_next   = op_query_reg;
        val_next        = val_reg;
        node_next       = node_reg;
        best_next       = best_reg;
        l_next          = l_reg;
        r_next          = r_reg;
        pend_l_next     = pend_l_reg;
        pend_r_next     = pend_r_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        mem_we          = 1'b0;
        mem_waddr       = node_reg;
        mem_wdata       = best_reg;
        mem_re          = 1'b0;
        mem_raddr       = node_reg;
        absorb          = best_reg;
        parent          = node_reg >> 1;
        r_dec           = r_reg - Q_W'(1);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    op_query_next = 1'b0;
                    best_next     = EMPTY_VAL;
                    priority case (s_tuser)
                        KIND_CLEAR: begin
                            sweep_next      = '0;
                            clear_pend_next = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                        KIND_LOWER: begin
                            if (NODE_W'(in_lo) >= NODE_W'(SIZE)) begin
                                state_next = ST_RESP;
                            end else begin
                                node_next  = NODE_W'(SIZE) + NODE_W'(in_lo);
                                val_next   = in_val;
                                mem_re     = 1'b1;
                                mem_raddr  = NODE_W'(SIZE) + NODE_W'(in_lo);
                                state_next = ST_L_CMP;
                            end
                        end
                        KIND_QUERY: begin
                            op_query_next = 1'b1;
                            if (in_lo > in_hi || NODE_W'(in_lo) >= NODE_W'(SIZE)) begin
                                state_next = ST_RESP;
                            end else begin
                                l_next      = Q_W'(SIZE) + Q_W'(in_lo);
                                r_next      = Q_W'(SIZE) + Q_W'(hi_eff) + Q_W'(1);
                                pend_l_next = 1'b0;
                                pend_r_next = 1'b0;
                                state_next  = ST_Q_A;
                            end
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SWEEP: begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = EMPTY_VAL;
                sweep_next = sweep_reg + NODE_W'(1);
                if (sweep_reg == NODE_W'(NODE_COUNT - 1)) begin
                    clear_pend_next = 1'b0;
                    state_next      = clear_pend_reg ? ST_RESP : ST_IDLE;
                end
            end

            ST_L_CMP: begin
                if (mem_rdata_reg <= val_reg) begin
                    state_next = ST_RESP;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = node_reg;
                    mem_wdata  = val_reg;
                    best_next  = val_reg;
                    mem_re     = 1'b1;
                    mem_raddr  = node_reg ^ NODE_W'(1);
                    state_next = ST_U_WR;
                end
            end

            ST_U_WR: begin
                // sibling data is back: write the parent, fetch the parent's sibling
                absorb    = val_min(best_reg, mem_rdata_reg);
                best_next = absorb;
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = absorb;
                node_next = parent;
                if (parent == NODE_W'(1)) begin
                    state_next = ST_RESP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = parent ^ NODE_W'(1);
                end
            end

            ST_Q_A: begin
                absorb    = pend_r_reg ? val_min(best_reg, mem_rdata_reg) : best_reg;
                best_next = absorb;
                if (l_reg >= r_reg) begin
                    state_next = ST_RESP;
                end else begin
                    pend_l_next = l_reg[0];
                    if (l_reg[0]) begin
                        mem_re    = 1'b1;
                        mem_raddr = l_reg[NODE_W-1:0];
                        l_next    = l_reg + Q_W'(1);
                    end
                    state_next = ST_Q_B;
                end
            end

            ST_Q_B: begin
                absorb      = pend_l_reg ? val_min(best_reg, mem_rdata_reg) : best_reg;
                best_next   = absorb;
                pend_r_next = r_reg[0];
                l_next      = l_reg >> 1;
                if (r_reg[0]) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_dec[NODE_W-1:0];
                    r_next    = r_dec >> 1;
                end else begin
                    r_next    = r_reg >> 1;
                end
                state_next = ST_Q_A;
            end

            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    if (op_query_reg && best_reg != EMPTY_VAL) begin
                        m_tdata_next = M_TDATA_W'(best_reg);
                        m_tuser_next = 1'b0;
                    end else begin
                        m_tdata_next = '0;
                        m_tuser_next = op_query_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            sweep_reg      <= '0;
            clear_pend_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            clear_pend_reg <= clear_pend_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge aclk) begin
        op_query_reg <= op_query_next;
        val_reg      <= val_next;
        node_reg     <= node_next;
        best_reg     <= best_next;
        l_reg        <= l_next;
        r_reg        <= r_next;
        pend_l_reg   <= pend_l_next;
        pend_r_reg   <= pend_r_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/rmt_checker.sv
// Port-level checks for range_min_tree, bound to the top level.
// Depends on rmt_pkg and range_min_tree.
module rmt_checker
    import rmt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // empty results carry a zero value
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("empty result with nonzero value");

    // one transaction in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // clearing pass holds off input after reset
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("input open or result shown right after reset");

endmodule

bind range_min_tree rmt_checker u_rmt_checker (.*);
